// ===== rtl/qapd_pkg.sv =====
`default_nettype none
package qapd_pkg;

  // Field widths
  localparam int unsigned IN_W     = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned PROD_W   = 32;  // Q2.14 x Q2.14
  localparam int unsigned ERR_W    = 34;  // sum of four products, Q6.28
  localparam int unsigned TORQUE_W = 32;
  localparam int unsigned STAGES   = 7;

  // APB register map (word index)
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned IDX_W   = 3;
  localparam logic [IDX_W-1:0] REG_ATT_GAIN  = 3'd0;
  localparam logic [IDX_W-1:0] REG_RATE_GAIN = 3'd1;
  localparam logic [IDX_W-1:0] REG_INERTIA_X = 3'd2;
  localparam logic [IDX_W-1:0] REG_INERTIA_Y = 3'd3;
  localparam logic [IDX_W-1:0] REG_INERTIA_Z = 3'd4;

  // Input item, last field (ref_w) in the lowest bits
  typedef struct packed {
    logic signed [IN_W-1:0] rate_z;
    logic signed [IN_W-1:0] rate_y;
    logic signed [IN_W-1:0] rate_x;
    logic signed [IN_W-1:0] meas_z;
    logic signed [IN_W-1:0] meas_y;
    logic signed [IN_W-1:0] meas_x;
    logic signed [IN_W-1:0] meas_w;
    logic signed [IN_W-1:0] ref_z;
    logic signed [IN_W-1:0] ref_y;
    logic signed [IN_W-1:0] ref_x;
    logic signed [IN_W-1:0] ref_w;
  } in_item_t;

  // Result item, last field (torque_x) in the lowest bits
  typedef struct packed {
    logic signed [TORQUE_W-1:0] torque_z;
    logic signed [TORQUE_W-1:0] torque_y;
    logic signed [TORQUE_W-1:0] torque_x;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [CFG_W-1:0] attitude_gain;
    logic [CFG_W-1:0] rate_gain;
    logic [CFG_W-1:0] inertia_xx;
    logic [CFG_W-1:0] inertia_yy;
    logic [CFG_W-1:0] inertia_zz;
  } cfg_t;

endpackage
`default_nettype wire

// ===== rtl/qapd_regs.sv =====
`default_nettype none
module qapd_regs import qapd_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [PADDR_W-1:0]   paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg
);

  logic             wr;
  logic [IDX_W-1:0] idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign idx    = paddr[PADDR_W-1:2];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr) begin
      unique case (idx)
        REG_ATT_GAIN:  cfg.attitude_gain <= pwdata[CFG_W-1:0];
        REG_RATE_GAIN: cfg.rate_gain     <= pwdata[CFG_W-1:0];
        REG_INERTIA_X: cfg.inertia_xx    <= pwdata[CFG_W-1:0];
        REG_INERTIA_Y: cfg.inertia_yy    <= pwdata[CFG_W-1:0];
        REG_INERTIA_Z: cfg.inertia_zz    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Read-back
  always_comb begin
    unique case (idx)
      REG_ATT_GAIN:  prdata = 32'(cfg.attitude_gain);
      REG_RATE_GAIN: prdata = 32'(cfg.rate_gain);
      REG_INERTIA_X: prdata = 32'(cfg.inertia_xx);
      REG_INERTIA_Y: prdata = 32'(cfg.inertia_yy);
      REG_INERTIA_Z: prdata = 32'(cfg.inertia_zz);
      default:       prdata = '0;
    endcase
  end

  a_gain_write: assert property (@(posedge clk) disable iff (rst)
    (wr && idx == REG_ATT_GAIN) |=> cfg.attitude_gain == $past(pwdata[CFG_W-1:0]))
    else $error("attitude gain not taken from the write transfer");

endmodule
`default_nettype wire

// ===== rtl/qapd_err.sv =====
`default_nettype none
module qapd_err import qapd_pkg::*; (
  input  wire                       clk,
  input  wire [2:0]                 en,      // stages 1 to 3
  input  in_item_t                  item,
  output logic signed [ERR_W-1:0]   axis_x,
  output logic signed [ERR_W-1:0]   axis_y,
  output logic signed [ERR_W-1:0]   axis_z,
  output logic signed [IN_W-1:0]    rate_x,
  output logic signed [IN_W-1:0]    rate_y,
  output logic signed [IN_W-1:0]    rate_z
);

  logic signed [PROD_W-1:0] prod [16];
  logic signed [IN_W-1:0]   r1_x, r1_y, r1_z, r2_x, r2_y, r2_z;
  logic signed [ERR_W-1:0]  ew, ex, ey, ez;

  // Stage 1: the sixteen products of conj(ref) * meas
  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod[0]  <= item.ref_w * item.meas_w;
      prod[1]  <= item.ref_x * item.meas_x;
      prod[2]  <= item.ref_y * item.meas_y;
      prod[3]  <= item.ref_z * item.meas_z;
      prod[4]  <= item.ref_w * item.meas_x;
      prod[5]  <= item.ref_x * item.meas_w;
      prod[6]  <= item.ref_y * item.meas_z;
      prod[7]  <= item.ref_z * item.meas_y;
      prod[8]  <= item.ref_w * item.meas_y;
      prod[9]  <= item.ref_x * item.meas_z;
      prod[10] <= item.ref_y * item.meas_w;
      prod[11] <= item.ref_z * item.meas_x;
      prod[12] <= item.ref_w * item.meas_z;
      prod[13] <= item.ref_x * item.meas_y;
      prod[14] <= item.ref_y * item.meas_x;
      prod[15] <= item.ref_z * item.meas_w;
      r1_x     <= item.rate_x;
      r1_y     <= item.rate_y;
      r1_z     <= item.rate_z;
    end
  end

  // Stage 2: error quaternion at full precision
  always_ff @(posedge clk) begin
    if (en[1]) begin
      ew   <= ERR_W'(prod[0]) + ERR_W'(prod[1]) + ERR_W'(prod[2]) + ERR_W'(prod[3]);
      ex   <= ERR_W'(prod[4]) - ERR_W'(prod[5]) - ERR_W'(prod[6]) + ERR_W'(prod[7]);
      ey   <= ERR_W'(prod[8]) + ERR_W'(prod[9]) - ERR_W'(prod[10]) - ERR_W'(prod[11]);
      ez   <= ERR_W'(prod[12]) - ERR_W'(prod[13]) + ERR_W'(prod[14]) - ERR_W'(prod[15]);
      r2_x <= r1_x;
      r2_y <= r1_y;
      r2_z <= r1_z;
    end
  end

  // Stage 3: negate the vector part when the scalar part is zero or positive
  always_ff @(posedge clk) begin
    if (en[2]) begin
      axis_x <= ew[ERR_W-1] ? ex : -ex;
      axis_y <= ew[ERR_W-1] ? ey : -ey;
      axis_z <= ew[ERR_W-1] ? ez : -ez;
      rate_x <= r2_x;
      rate_y <= r2_y;
      rate_z <= r2_z;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/qapd_axis.sv =====
`default_nettype none
module qapd_axis import qapd_pkg::*; (
  input  wire                         clk,
  input  wire [3:0]                   en,      // stages 4 to 7
  input  wire [CFG_W-1:0]             attitude_gain,
  input  wire [CFG_W-1:0]             rate_gain,
  input  wire [CFG_W-1:0]             inertia,
  input  wire signed [ERR_W-1:0]      axis,
  input  wire signed [IN_W-1:0]       rate,
  output logic signed [TORQUE_W-1:0]  torque
);

  localparam int unsigned KP_PROD_W = ERR_W + CFG_W + 1;   // Kp * axis
  localparam int unsigned KD_PROD_W = IN_W + CFG_W + 1;    // Kd * rate
  localparam int unsigned P_W       = KP_PROD_W - 20;
  localparam int unsigned DIFF_W    = KD_PROD_W + 1;
  localparam int unsigned T_PROD_W  = DIFF_W + CFG_W + 1;  // diff * inertia
  localparam int unsigned T_W       = T_PROD_W - 16;

  localparam logic signed [TORQUE_W-1:0] TQ_MAX = {1'b0, {(TORQUE_W-1){1'b1}}};
  localparam logic signed [TORQUE_W-1:0] TQ_MIN = {1'b1, {(TORQUE_W-1){1'b0}}};

  logic signed [KP_PROD_W-1:0] kp_prod;
  logic signed [KD_PROD_W-1:0] kd_prod;
  logic signed [DIFF_W-1:0]    diff;
  logic signed [T_PROD_W-1:0]  t_prod;
  logic signed [T_W-1:0]       t_shift;
  logic                        t_hi, t_lo;

  // Stage 4: proportional and damping products side by side
  always_ff @(posedge clk) begin
    if (en[0]) begin
      kp_prod <= $signed({1'b0, attitude_gain}) * axis;
      kd_prod <= $signed({1'b0, rate_gain}) * rate;
    end
  end

  // Stage 5: floor the proportional term to Q16.16 and subtract damping
  always_ff @(posedge clk) begin
    if (en[1]) begin
      diff <= DIFF_W'(P_W'(kp_prod >>> 20)) - DIFF_W'(kd_prod);
    end
  end

  // Stage 6: scale by inertia
  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_prod <= diff * $signed({1'b0, inertia});
    end
  end

  // Stage 7: floor to Q16.16 and clamp to the 32-bit range
  assign t_shift = T_W'(t_prod >>> 16);
  assign t_hi    = !t_shift[T_W-1] && (|t_shift[T_W-2:TORQUE_W-1]);
  assign t_lo    = t_shift[T_W-1] && !(&t_shift[T_W-2:TORQUE_W-1]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      priority if (t_hi) torque <= TQ_MAX;
      else if (t_lo)     torque <= TQ_MIN;
      else               torque <= t_shift[TORQUE_W-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/quaternion_attitude_pd_torque.sv =====
`default_nettype none
// Quaternion PD attitude controller. Each transfer on the slave stream carries a
// reference attitude, a measured attitude (Q2.14) and a body rate (Q8.8); one
// torque transfer (Q16.16 per axis, saturated to 32 bits) leaves on the master
// stream for each of them. The datapath is a seven-stage register pipeline, so
// it takes one item every clock cycle while the output is not stalled. m_tvalid
// is the valid bit of the last stage. Back-pressure on m_tready holds every
// full stage whose later stages are all full, so bubbles close up and nothing is
// dropped. Gains and inertias are written over the APB port at byte addresses
// 0, 4, 8, 12 and 16 and should only be changed while no item is in flight.
module quaternion_attitude_pd_torque import qapd_pkg::*; (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 s_tvalid,
  output logic                s_tready,
  // ref_w, ref_x, ref_y, ref_z, meas_w, meas_x, meas_y, meas_z, rate_x, rate_y, rate_z
  input  wire [175:0]         s_tdata,
  output logic                m_tvalid,
  input  wire                 m_tready,
  // torque_x, torque_y, torque_z
  output logic [95:0]         m_tdata,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [PADDR_W-1:0]   paddr,
  input  wire [31:0]          pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t                     cfg;
  in_item_t                 item;
  out_item_t                res;
  logic [STAGES-1:0]        valid;
  logic [STAGES-1:0]        en;
  logic signed [ERR_W-1:0]  axis_x, axis_y, axis_z;
  logic signed [IN_W-1:0]   rate_x, rate_y, rate_z;

  assign item = in_item_t'(s_tdata);

  qapd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stage enables: a stage loads when it is empty or its successor moves on
  always_comb begin
    en[STAGES-1] = !valid[STAGES-1] || m_tready;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[STAGES-1];

  // Advance valid bits with their data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) valid[0] <= s_tvalid;
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) valid[i] <= valid[i-1];
      end
    end
  end

  qapd_err u_err (
    .clk    (clk),
    .en     (en[2:0]),
    .item   (item),
    .axis_x (axis_x),
    .axis_y (axis_y),
    .axis_z (axis_z),
    .rate_x (rate_x),
    .rate_y (rate_y),
    .rate_z (rate_z)
  );

  qapd_axis u_axis_x (
    .clk           (clk),
    .en            (en[6:3]),
    .attitude_gain (cfg.attitude_gain),
    .rate_gain     (cfg.rate_gain),
    .inertia       (cfg.inertia_xx),
    .axis          (axis_x),
    .rate          (rate_x),
    .torque        (res.torque_x)
  );

  qapd_axis u_axis_y (
    .clk           (clk),
    .en            (en[6:3]),
    .attitude_gain (cfg.attitude_gain),
    .rate_gain     (cfg.rate_gain),
    .inertia       (cfg.inertia_yy),
    .axis          (axis_y),
    .rate          (rate_y),
    .torque        (res.torque_y)
  );

  qapd_axis u_axis_z (
    .clk           (clk),
    .en            (en[6:3]),
    .attitude_gain (cfg.attitude_gain),
    .rate_gain     (cfg.rate_gain),
    .inertia       (cfg.inertia_zz),
    .axis          (axis_z),
    .rate          (rate_z),
    .torque        (res.torque_z)
  );

  assign m_tdata = 96'(res);

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (&valid && !m_tready))
    else $error("input stalled while the pipeline has a free stage");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> valid == '0)
    else $error("pipeline not empty after reset");

  a_last_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (valid[STAGES-1] && !m_tready) |=> valid[STAGES-1])
    else $error("stalled result lost");

endmodule
`default_nettype wire

// ===== dv/quaternion_attitude_pd_torque_tb.sv =====
`default_nettype none
module quaternion_attitude_pd_torque_tb;

  timeunit 1ns;
  timeprecision 1ps;

  import qapd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 4 * STAGES;
  localparam int RANDOM_PHASES = 10;
  localparam int SAMPLES_PER_PHASE = 145;
  localparam longint TORQUE_HI = 64'sd2147483647;
  localparam longint TORQUE_LO = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic s_tvalid = 1'b0;
  logic s_tready;
  in_item_t s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b1;
  out_item_t m_tdata;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  // Shadow of the register set, and the torques still owed by the block
  cfg_t shadow_cfg = '0;
  in_item_t pending_samples[$];
  out_item_t torque_due[$];

  // Traffic shaping
  logic sender_gaps = 1'b1;
  int rx_mode = 1;
  int gap_left = 0;
  int burst_left = 1;
  logic drain_wait = 1'b0;
  int run_left = 0;
  logic in_taken = 1'b0;

  int cycle_count = 0;
  int error_count = 0;
  int samples_sent = 0;
  int torques_checked = 0;
  int saturated_seen = 0;
  int drains_seen = 0;
  int settings_used = 0;
  out_item_t want;

  quaternion_attitude_pd_torque dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial forever #1 clk = ~clk;

  function automatic longint sx16(logic [15:0] v);
    return longint'($signed(v));
  endfunction

  // One axis: Kp*axis to Q16.16, minus Kd*rate, times inertia, floor, saturate
  function automatic logic [31:0] axis_torque_q16(longint axis, longint rate,
                                                  logic [CFG_W-1:0] inertia);
    longint p, d, t;
    p = (longint'(shadow_cfg.attitude_gain) * axis) >>> 20;
    d = longint'(shadow_cfg.rate_gain) * rate;
    t = ((p - d) * longint'(inertia)) >>> 16;
    if (t > TORQUE_HI) begin
      t = TORQUE_HI;
    end else if (t < TORQUE_LO) begin
      t = TORQUE_LO;
    end
    return t[31:0];
  endfunction

  // Error quaternion conj(ref) * meas, axis steered the short way round
  function automatic out_item_t predict_torque(in_item_t it);
    longint rw, rx, ry, rz, mw, mx, my, mz, ew, ex, ey, ez;
    out_item_t r;
    rw = sx16(it.ref_w);  rx = sx16(it.ref_x);  ry = sx16(it.ref_y);  rz = sx16(it.ref_z);
    mw = sx16(it.meas_w); mx = sx16(it.meas_x); my = sx16(it.meas_y); mz = sx16(it.meas_z);
    ew = rw * mw + rx * mx + ry * my + rz * mz;
    ex = rw * mx - rx * mw - ry * mz + rz * my;
    ey = rw * my + rx * mz - ry * mw - rz * mx;
    ez = rw * mz - rx * my + ry * mx - rz * mw;
    if (ew >= 0) begin
      ex = -ex;
      ey = -ey;
      ez = -ez;
    end
    r.torque_x = axis_torque_q16(ex, sx16(it.rate_x), shadow_cfg.inertia_xx);
    r.torque_y = axis_torque_q16(ey, sx16(it.rate_y), shadow_cfg.inertia_yy);
    r.torque_z = axis_torque_q16(ez, sx16(it.rate_z), shadow_cfg.inertia_zz);
    return r;
  endfunction

  function automatic logic [15:0] f16(int v);
    return v[15:0];
  endfunction

  function automatic in_item_t build_sample(int rw, int rx, int ry, int rz,
                                            int mw, int mx, int my, int mz,
                                            int wx, int wy, int wz);
    in_item_t it;
    it.ref_w = f16(rw);  it.ref_x = f16(rx);  it.ref_y = f16(ry);  it.ref_z = f16(rz);
    it.meas_w = f16(mw); it.meas_x = f16(mx); it.meas_y = f16(my); it.meas_z = f16(mz);
    it.rate_x = f16(wx); it.rate_y = f16(wy); it.rate_z = f16(wz);
    return it;
  endfunction

  function automatic int rnd_span(int lo, int hi);
    return int'($urandom_range(0, hi - lo)) + lo;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_cfg();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 16'd1;
      default: return CFG_W'($urandom);
    endcase
  endfunction

  // Random sample: half are measurements close to a random reference, plus noise and corner cases
  task automatic queue_random_sample();
    int kind, qw, qx, qy, qz, wx, wy, wz, s;
    in_item_t it;
    kind = $urandom_range(0, 9);
    qw = rnd_span(-16384, 16384);
    qx = rnd_span(-16384, 16384);
    qy = rnd_span(-16384, 16384);
    qz = rnd_span(-16384, 16384);
    if ($urandom_range(0, 1) == 0) begin
      wx = rnd_span(-2048, 2048);
      wy = rnd_span(-2048, 2048);
      wz = rnd_span(-2048, 2048);
    end else begin
      wx = int'($urandom);
      wy = int'($urandom);
      wz = int'($urandom);
    end
    case (kind)
      0, 1: begin
        it = build_sample(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                          int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                          int'($urandom), int'($urandom), int'($urandom));
      end
      7: begin
        // meas orthogonal to ref, so the error scalar is exactly zero
        it = build_sample(qw, qx, qy, qz, -qx, qw, -qz, qy, wx, wy, wz);
      end
      8: begin
        it = build_sample(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), pick_extreme());
      end
      9: begin
        it = build_sample(qw, qx, qy, qz, 0, 0, 0, 0, wx, wy, wz);
      end
      default: begin
        // flip the measurement now and then to land on the far hemisphere
        s = ($urandom_range(0, 3) == 0) ? -1 : 1;
        it = build_sample(qw, qx, qy, qz,
                          s * (qw + rnd_span(-600, 600)), s * (qx + rnd_span(-600, 600)),
                          s * (qy + rnd_span(-600, 600)), s * (qz + rnd_span(-600, 600)),
                          wx, wy, wz);
      end
    endcase
    pending_samples.push_back(it);
  endtask

  // Setup cycle then access cycle; the shadow follows the access edge
  task automatic apb_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    while (!pready) @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (addr[PADDR_W-1:2])
      REG_ATT_GAIN:  shadow_cfg.attitude_gain = data[CFG_W-1:0];
      REG_RATE_GAIN: shadow_cfg.rate_gain = data[CFG_W-1:0];
      REG_INERTIA_X: shadow_cfg.inertia_xx = data[CFG_W-1:0];
      REG_INERTIA_Y: shadow_cfg.inertia_yy = data[CFG_W-1:0];
      REG_INERTIA_Z: shadow_cfg.inertia_zz = data[CFG_W-1:0];
      default: ;
    endcase
  endtask

  // Load all five registers, then poke an unmapped index that must be ignored
  task automatic load_gains(logic [CFG_W-1:0] kp, logic [CFG_W-1:0] kd,
                            logic [CFG_W-1:0] ix, logic [CFG_W-1:0] iy,
                            logic [CFG_W-1:0] iz);
    logic [IDX_W-1:0] spare_idx;
    apb_write({REG_ATT_GAIN, 2'b00}, {16'($urandom), kp});
    apb_write({REG_RATE_GAIN, 2'b00}, {16'($urandom), kd});
    apb_write({REG_INERTIA_X, 2'b00}, {16'($urandom), ix});
    apb_write({REG_INERTIA_Y, 2'b00}, {16'($urandom), iy});
    apb_write({REG_INERTIA_Z, 2'b00}, {16'($urandom), iz});
    spare_idx = IDX_W'($urandom_range(5, 7));
    apb_write({spare_idx, 2'b00}, $urandom);
    settings_used++;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || s_tvalid || torque_due.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic note_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    error_count++;
    if (error_count <= 10)
      $display("mismatch %s: expected %0d (%h), got %0d (%h)", what,
               $signed(exp_v), exp_v, $signed(got_v), got_v);
  endtask

  // Sender: bursts with gaps, and now and then hold until the pipe is empty
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_taken) begin
      // hold the current transfer
    end else if (drain_wait) begin
      s_tvalid <= 1'b0;
      if (torque_due.size() == 0) drain_wait <= 1'b0;
    end else if (gap_left != 0) begin
      s_tvalid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_samples.size() != 0) begin
      s_tdata <= pending_samples.pop_front();
      s_tvalid <= 1'b1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 40);
        gap_left <= sender_gaps ? $urandom_range(1, 6) : 0;
        if ($urandom_range(0, 199) == 0) begin
          drain_wait <= 1'b1;
          drains_seen++;
        end
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  // Receiver: alternate ready and stall runs, or stay ready
  always @(negedge clk) begin
    if (rst || rx_mode == 0) begin
      m_tready <= 1'b1;
    end else if (run_left != 0) begin
      run_left <= run_left - 1;
    end else begin
      m_tready <= !m_tready;
      run_left <= m_tready ? $urandom_range(0, rx_mode == 1 ? 3 : 24) : $urandom_range(0, 10);
    end
  end

  // Check each torque transfer against the oldest prediction, then log inputs
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      if (torque_due.size() == 0) begin
        note_mismatch("unexpected torque_x", '0, m_tdata.torque_x);
      end else begin
        want = torque_due.pop_front();
        torques_checked++;
        if (want.torque_x == 32'h7FFF_FFFF || want.torque_x == 32'h8000_0000 ||
            want.torque_y == 32'h7FFF_FFFF || want.torque_y == 32'h8000_0000 ||
            want.torque_z == 32'h7FFF_FFFF || want.torque_z == 32'h8000_0000)
          saturated_seen++;
        if (m_tdata.torque_x !== want.torque_x)
          note_mismatch("torque_x", want.torque_x, m_tdata.torque_x);
        if (m_tdata.torque_y !== want.torque_y)
          note_mismatch("torque_y", want.torque_y, m_tdata.torque_y);
        if (m_tdata.torque_z !== want.torque_z)
          note_mismatch("torque_z", want.torque_z, m_tdata.torque_z);
      end
    end
    if (!rst && s_tvalid && s_tready) begin
      torque_due.push_back(predict_torque(s_tdata));
      samples_sent++;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("quaternion_attitude_pd_torque_tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset gains: every torque must be zero
    repeat (3) queue_random_sample();
    wait_drained();

    // Unity gains, mixed inertias: identity, quarter turn, zero scalar,
    // far hemisphere, non-unit quaternions and rate-only samples
    load_gains(16'h0100, 16'h0100, 16'h4000, 16'h8000, 16'hFFFF);
    pending_samples.push_back(build_sample(16384, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0));
    pending_samples.push_back(build_sample(16384, 0, 0, 0, 11585, 11585, 0, 0,
                                           256, -256, 512));
    pending_samples.push_back(build_sample(16384, 0, 0, 0, 0, 16384, 0, 0, 0, 0, 0));
    pending_samples.push_back(build_sample(16384, 0, 0, 0, -16000, 3000, -2000, 1000,
                                           -100, 50, 0));
    pending_samples.push_back(build_sample(16384, 0, 0, 0, 16000, 3000, -2000, 1000,
                                           -100, 50, 0));
    pending_samples.push_back(build_sample(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_samples.push_back(build_sample(32767, 32767, 32767, 32767, 1, -1, 1, -1,
                                           32767, -32768, 1));
    pending_samples.push_back(build_sample(0, 0, 0, 0, 0, 0, 0, 0, -32768, 32767, -1));
    wait_drained();

    // Full-scale gains and inertias: field extremes driving both saturation limits
    load_gains('1, '1, '1, '1, '1);
    pending_samples.push_back(build_sample(-32768, -32768, -32768, -32768, -32768, -32768,
                                           -32768, -32768, -32768, -32768, -32768));
    pending_samples.push_back(build_sample(32767, 32767, 32767, 32767, 32767, 32767,
                                           32767, 32767, 32767, 32767, 32767));
    pending_samples.push_back(build_sample(-32768, 32767, 32767, 32767, -32768, -32768,
                                           -32768, -32768, -32768, -32768, -32768));
    pending_samples.push_back(build_sample(-32768, 32767, 32767, 32767, -32768, -32768,
                                           -32768, -32768, 32767, 32767, 32767));
    pending_samples.push_back(build_sample(32767, -32768, 32767, -32768, -32768, 32767,
                                           -32768, 32767, 32767, -32768, 0));
    pending_samples.push_back(build_sample(0, 32767, 0, 0, 32767, 0, 0, 0, 0, 0, 0));
    repeat (30) queue_random_sample();
    wait_drained();

    // Random settings, each with its own idle pattern; one phase runs flat out
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      load_gains(pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg(), pick_cfg());
      sender_gaps = (ph == 0) ? 1'b0 : 1'($urandom_range(0, 3) != 0);
      rx_mode = (ph == 0) ? 0 : $urandom_range(0, 2);
      repeat (SAMPLES_PER_PHASE) queue_random_sample();
      wait_drained();
    end

    // Bounded settle for stray transfers, then count anything still owed
    for (int n = 0; n < 1000 && torque_due.size() != 0; n++) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    error_count += torque_due.size();

    $display("covered %0d samples over %0d register settings, %0d torques checked",
             samples_sent, settings_used, torques_checked);
    $display("%0d torques hit a saturation limit, %0d full drains of the pipeline",
             saturated_seen, drains_seen);
    if (error_count == 0) begin
      $display("quaternion_attitude_pd_torque_tb: done, clean");
    end else begin
      $display("quaternion_attitude_pd_torque_tb: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== quaternion_attitude_pd_torque.f =====
rtl/qapd_pkg.sv
rtl/qapd_regs.sv
rtl/qapd_err.sv
rtl/qapd_axis.sv
rtl/quaternion_attitude_pd_torque.sv
dv/quaternion_attitude_pd_torque_tb.sv
